// ===== hw/rtl/greedy_cluster_track_association_unit_macros.svh =====
// Assertion helpers for the track association block.
// All checks are clocked on i_clk and held off while i_rst_n is low.
`ifndef GREEDY_CLUSTER_TRACK_ASSOCIATION_UNIT_MACROS_SVH
`define GREEDY_CLUSTER_TRACK_ASSOCIATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define GCTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcta: same-cycle check failed");

// Next-cycle implication.
`define GCTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcta: next-cycle check failed");

`endif

// ===== hw/rtl/gcta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcta_pkg;

    localparam int MAX_TRACKS_DEF = 32;
    localparam int ID_BITS_DEF    = 16;

    localparam int CENT_W  = 19;
    localparam int DT_W    = 16;
    localparam int TID_W   = 16;
    localparam int DIST_W  = 20;
    localparam int LIMIT_W = 8;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam int ABS_W = CENT_W;          // |a-b| of two 19-bit signed values
    localparam int SQ_W  = 2 * ABS_W;
    localparam int D2_W  = SQ_W + 2;
    localparam int D2_HALF = D2_W / 2;

    localparam int MEGA_W = 20;
    localparam logic [MEGA_W-1:0] MEGA = MEGA_W'(1000000);

    localparam logic [LIMIT_W-1:0] MISS_SAT = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd2;

    localparam logic [DIST_W-1:0]  MAX_DIST_RST  = DIST_W'(1000);
    localparam logic [LIMIT_W-1:0] MISS_LIM_RST  = LIMIT_W'(5);
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = SPEED_W'(300);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_SPD1,
        ST_SPD2,
        ST_SPD3,
        ST_EOF,
        ST_EOF_END
    } t_state;

    typedef struct packed {
        logic vld;
        logic live;
        logic elig;
        logic last;
    } t_dist_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/gcta_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcta_slot_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gcta_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-stage squared distance: abs diffs, squares, sum.
module gcta_dist
    import gcta_pkg::*;
#(
    parameter int TAG_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dist_ctl         i_ctl,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [CENT_W-1:0] i_ax,
    input  wire logic [CENT_W-1:0] i_ay,
    input  wire logic [CENT_W-1:0] i_az,
    input  wire logic [CENT_W-1:0] i_bx,
    input  wire logic [CENT_W-1:0] i_by,
    input  wire logic [CENT_W-1:0] i_bz,
    output t_dist_ctl              o_ctl,
    output logic      [TAG_W-1:0]  o_tag,
    output logic      [D2_W-1:0]   o_d2
);

    function automatic logic [ABS_W-1:0] f_absdiff(logic [CENT_W-1:0] a,
                                                   logic [CENT_W-1:0] b);
        logic [CENT_W:0] d;
        d = {a[CENT_W-1], a} - {b[CENT_W-1], b};
        return d[CENT_W] ? ABS_W'(~d + 1'b1) : ABS_W'(d);
    endfunction

    t_dist_ctl            r_ctl1, r_ctl2;
    logic [TAG_W-1:0]     r_tag1, r_tag2;
    logic [ABS_W-1:0]     r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]      r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            o_ctl  <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            o_ctl  <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_dx   <= f_absdiff(i_ax, i_bx);
        r_dy   <= f_absdiff(i_ay, i_by);
        r_dz   <= f_absdiff(i_az, i_bz);
        r_tag2 <= r_tag1;
        r_sx   <= r_dx * r_dx;
        r_sy   <= r_dy * r_dy;
        r_sz   <= r_dz * r_dz;
        o_tag  <= r_tag2;
        o_d2   <= D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/greedy_cluster_track_association_unit.sv =====
// Centroid beat: o_valid strobes after the slot scan (one slot memory read per cycle),
//   the 3-stage distance pipe, the decision and the speed-check states ST_SPD1..ST_SPD3;
//   on no_room it strobes straight from the decision. busy drops with the strobe.
// End-of-frame beat: busy through the slot scan and a final write-back, no result; start is taken only when not busy.
// Results are strobed, the receiver cannot stall.
// Reset (synchronous, i_rst_n low): all slots free, frame marks clear, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module greedy_cluster_track_association_unit
    import gcta_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // command
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_req_type,
    input  wire logic signed [CENT_W-1:0] i_cent_x,
    input  wire logic signed [CENT_W-1:0] i_cent_y,
    input  wire logic signed [CENT_W-1:0] i_cent_z,
    input  wire logic [DT_W-1:0]      i_frame_dt_ms,
    // result
    output logic                      o_valid,
    output logic [TID_W-1:0]          o_track_id,
    output logic                      o_is_new,
    output logic                      o_is_dynamic,
    output logic                      o_no_room
);

    localparam int SW     = $clog2(MAX_TRACKS);
    localparam int WORD_W = ID_BITS + 3 * CENT_W + LIMIT_W;
    localparam int TAG_W  = SW + ID_BITS;
    localparam int PROD_W = 2 * (DT_W + SPEED_W);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TRACKS - 1);

    // slot word layout: {id, x, y, z, missed}
    localparam int MISS_LO = 0;
    localparam int Z_LO    = LIMIT_W;
    localparam int Y_LO    = Z_LO + CENT_W;
    localparam int X_LO    = Y_LO + CENT_W;
    localparam int ID_LO   = X_LO + CENT_W;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [DIST_W-1:0]  r_max_dist;
    logic [LIMIT_W-1:0] r_miss_lim;
    logic [SPEED_W-1:0] r_min_speed;
    logic [2*DIST_W-1:0] r_lim2;     // squared association limit, kept current

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist  <= MAX_DIST_RST;
            r_miss_lim  <= MISS_LIM_RST;
            r_min_speed <= MIN_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                CFG_MISS_LIM:  r_miss_lim  <= i_cfg_data[LIMIT_W-1:0];
                CFG_MIN_SPEED: r_min_speed <= i_cfg_data[SPEED_W-1:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim2 <= r_max_dist * r_max_dist;
    end

    // ---------------------------------------------------------------------
    // per-slot flags in flops; payload lives in the slot memory
    // ---------------------------------------------------------------------
    logic [MAX_TRACKS-1:0] r_valid, r_used, r_born;

    t_state r_state, n_state;

    // latched beat
    logic              r_eof;
    logic [CENT_W-1:0] r_cx, r_cy, r_cz;
    logic [DT_W-1:0]   r_dt;

    // scan issue and read-request stage
    logic [SW-1:0] r_rd_idx;
    t_dist_ctl     r_rq_ctl;
    logic [SW-1:0] r_rq_slot;

    // memory port
    logic              ram_we;
    logic [SW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    gcta_slot_ram #(
        .DEPTH (MAX_TRACKS),
        .AW    (SW),
        .DW    (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // distance pipe, fed the beat the read data lands
    t_dist_ctl         dist_ctl_in, dist_ctl_out;
    logic [TAG_W-1:0]  dist_tag_out;
    logic [D2_W-1:0]   dist_d2;
    logic [SW-1:0]     out_slot;
    logic [ID_BITS-1:0] out_id;

    assign dist_ctl_in = r_eof ? '0 : r_rq_ctl;

    gcta_dist #(
        .TAG_W (TAG_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dist_ctl_in),
        .i_tag   ({r_rq_slot, ram_rdata[ID_LO +: ID_BITS]}),
        .i_ax    (ram_rdata[X_LO +: CENT_W]),
        .i_ay    (ram_rdata[Y_LO +: CENT_W]),
        .i_az    (ram_rdata[Z_LO +: CENT_W]),
        .i_bx    (r_cx),
        .i_by    (r_cy),
        .i_bz    (r_cz),
        .o_ctl   (dist_ctl_out),
        .o_tag   (dist_tag_out),
        .o_d2    (dist_d2)
    );

    assign out_slot = dist_tag_out[ID_BITS +: SW];
    assign out_id   = dist_tag_out[ID_BITS-1:0];

    // scan results
    logic               r_any, r_best_vld, r_free_vld;
    logic [ID_BITS-1:0] r_maxid, r_best_id;
    logic [D2_W-1:0]    r_best_d2;
    logic [SW-1:0]      r_best_slot, r_free_slot;

    // decision / speed check
    logic               no_room, new_trk;
    logic [ID_BITS-1:0] new_id;
    logic [ID_BITS-1:0] r_res_id;
    logic               r_res_new;
    logic [D2_W-1:0]    r_d2_sel;
    logic [D2_HALF+MEGA_W-1:0] r_plo, r_phi;
    logic [DT_W+SPEED_W-1:0]   r_lim;
    logic [PROD_W-1:0]  r_limsq;
    logic [PROD_W-1:0]  prod_sum;
    logic               dyn;

    // end-of-frame ageing of the slot whose word has just come back
    logic [LIMIT_W-1:0] aged_miss;
    logic               eof_wr;

    assign no_room  = !r_free_vld || (r_any && (&r_maxid));
    assign new_trk  = !r_best_vld && !no_room;
    assign new_id   = r_any ? r_maxid + 1'b1 : '0;
    assign eof_wr   = r_eof && r_rq_ctl.vld && r_rq_ctl.elig;
    assign aged_miss = (ram_rdata[MISS_LO +: LIMIT_W] == MISS_SAT) ?
                       MISS_SAT : ram_rdata[MISS_LO +: LIMIT_W] + 1'b1;

    // d2 * 1e6 rebuilt from two half products
    assign prod_sum = PROD_W'({r_phi, {D2_HALF{1'b0}}}) + PROD_W'(r_plo);
    assign dyn = (r_dt == '0) ? (r_min_speed == '0) : (prod_sum >= r_limsq);

    assign busy = (r_state != ST_IDLE);

    // ---------------------------------------------------------------------
    // sequencer: next state and memory port
    // ---------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_rq_slot;
        ram_wdata = ram_rdata;
        ram_raddr = r_rd_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = i_req_type ? ST_EOF : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == LAST_SLOT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_ctl_out.vld && dist_ctl_out.last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_best_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_best_slot;
                    ram_wdata = {r_best_id, r_cx, r_cy, r_cz, {LIMIT_W{1'b0}}};
                    n_state   = ST_SPD1;
                end else if (no_room) begin
                    n_state = ST_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_free_slot;
                    ram_wdata = {new_id, r_cx, r_cy, r_cz, {LIMIT_W{1'b0}}};
                    n_state   = ST_SPD1;
                end
            end
            ST_SPD1: n_state = ST_SPD2;
            ST_SPD2: n_state = ST_SPD3;
            ST_SPD3: n_state = ST_IDLE;
            // read slot s while writing back s-1: never the same entry
            ST_EOF: begin
                ram_we    = eof_wr;
                ram_wdata = {ram_rdata[WORD_W-1:LIMIT_W], aged_miss};
                if (r_rd_idx == LAST_SLOT) begin
                    n_state = ST_EOF_END;
                end
            end
            ST_EOF_END: begin
                ram_we    = eof_wr;
                ram_wdata = {ram_rdata[WORD_W-1:LIMIT_W], aged_miss};
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_rq_ctl   <= '0;
            r_valid    <= '0;
            r_used     <= '0;
            r_born     <= '0;
            r_eof      <= 1'b0;
            r_any      <= 1'b0;
            r_best_vld <= 1'b0;
            r_free_vld <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            // strobe after the speed check, or straight from the decision on no_room
            o_valid <= (r_state == ST_SPD3) ||
                       (r_state == ST_DECIDE && !r_best_vld && no_room);

            // issue side of either scan
            if (r_state == ST_SCAN || r_state == ST_EOF) begin
                r_rq_ctl <= '{vld:  1'b1,
                              live: r_valid[r_rd_idx],
                              elig: r_valid[r_rd_idx] && !r_used[r_rd_idx]
                                    && !r_born[r_rd_idx],
                              last: (r_rd_idx == LAST_SLOT)};
                r_rd_idx <= (r_rd_idx == LAST_SLOT) ? '0 : r_rd_idx + 1'b1;
            end else begin
                r_rq_ctl <= '0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_rd_idx <= '0;
                    if (start) begin
                        r_eof      <= i_req_type;
                        r_any      <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_free_vld <= 1'b0;
                    end
                end
                ST_SCAN, ST_DRAIN: begin
                    if (dist_ctl_out.vld) begin
                        if (dist_ctl_out.live) begin
                            r_any <= 1'b1;
                        end else if (!r_free_vld) begin
                            r_free_vld <= 1'b1;
                        end
                        if (dist_ctl_out.elig && (dist_d2 < D2_W'(r_lim2)) &&
                            (!r_best_vld || dist_d2 < r_best_d2 ||
                             (dist_d2 == r_best_d2 && out_id < r_best_id))) begin
                            r_best_vld <= 1'b1;
                        end
                    end
                end
                ST_DECIDE: begin
                    if (r_best_vld) begin
                        r_used[r_best_slot] <= 1'b1;
                    end else if (!no_room) begin
                        r_valid[r_free_slot] <= 1'b1;
                        r_born[r_free_slot]  <= 1'b1;
                        r_used[r_free_slot]  <= 1'b0;
                    end
                end
                ST_EOF, ST_EOF_END: begin
                    if (eof_wr && aged_miss > r_miss_lim) begin
                        r_valid[r_rq_slot] <= 1'b0;
                    end
                    if (r_state == ST_EOF_END) begin
                        r_used <= '0;
                        r_born <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rq_slot <= r_rd_idx;
        if (r_state == ST_IDLE && start) begin
            r_cx <= i_cent_x;
            r_cy <= i_cent_y;
            r_cz <= i_cent_z;
            r_dt <= i_frame_dt_ms;
        end
        if ((r_state == ST_SCAN || r_state == ST_DRAIN) && dist_ctl_out.vld) begin
            if (dist_ctl_out.live && (!r_any || out_id > r_maxid)) begin
                r_maxid <= out_id;
            end
            if (!dist_ctl_out.live && !r_free_vld) begin
                r_free_slot <= out_slot;
            end
            if (dist_ctl_out.elig && (dist_d2 < D2_W'(r_lim2)) &&
                (!r_best_vld || dist_d2 < r_best_d2 ||
                 (dist_d2 == r_best_d2 && out_id < r_best_id))) begin
                r_best_d2   <= dist_d2;
                r_best_id   <= out_id;
                r_best_slot <= out_slot;
            end
        end
        unique case (r_state)
            ST_DECIDE: begin
                r_res_id  <= r_best_vld ? r_best_id : new_id;
                r_res_new <= new_trk;
                r_d2_sel  <= r_best_vld ? r_best_d2 : '0;
                if (!r_best_vld && no_room) begin
                    o_track_id   <= '0;
                    o_is_new     <= 1'b0;
                    o_is_dynamic <= 1'b0;
                    o_no_room    <= 1'b1;
                end
            end
            ST_SPD1: begin
                r_plo <= r_d2_sel[D2_HALF-1:0] * MEGA;
                r_lim <= r_min_speed * r_dt;
            end
            ST_SPD2: begin
                r_phi   <= r_d2_sel[D2_W-1:D2_HALF] * MEGA;
                r_limsq <= r_lim * r_lim;
            end
            ST_SPD3: begin
                o_track_id   <= TID_W'(r_res_id);
                o_is_new     <= r_res_new;
                o_is_dynamic <= dyn;
                o_no_room    <= 1'b0;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
`include "greedy_cluster_track_association_unit_macros.svh"

    `GCTA_ASSERT_IMP(a_noroom_clean, o_valid && o_no_room, !o_is_new && !o_is_dynamic && (o_track_id == '0))
    `GCTA_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
    `GCTA_ASSERT_IMP(a_marks_disjoint, 1'b1, (r_used & r_born) == '0)
    `GCTA_ASSERT_IMP(a_used_is_live, 1'b1, (r_used & ~r_valid) == '0)

endmodule

`default_nettype wire

// ===== sim/greedy_cluster_track_association_unit_test.sv =====
`timescale 1ns / 1ps

module greedy_cluster_track_association_unit_test
    import gcta_pkg::*;
();

    localparam int NSLOT = MAX_TRACKS_DEF;
    localparam longint unsigned ID_TOP = (64'd1 << ID_BITS_DEF) - 1;
    // settle time before a register write, longer than the slowest beat
    localparam int SETTLE = NSLOT + 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

    typedef enum logic [1:0] {B_ITEM, B_CFG, B_SYNC} t_beat_kind;

    typedef struct {
        t_beat_kind                 kind;
        logic                       eof;
        logic signed [CENT_W-1:0]   x, y, z;
        logic [DT_W-1:0]            dt;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_W-1:0]           data;
    } t_beat;

    typedef struct {
        logic [TID_W-1:0] tid;
        logic             is_new;
        logic             dyn;
        logic             no_room;
    } t_assoc;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic i_req_type = 1'b0;
    logic signed [CENT_W-1:0] i_cent_x = '0, i_cent_y = '0, i_cent_z = '0;
    logic [DT_W-1:0] i_frame_dt_ms = '0;
    logic o_valid, o_is_new, o_is_dynamic, o_no_room;
    logic [TID_W-1:0] o_track_id;

    greedy_cluster_track_association_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_cent_x(i_cent_x), .i_cent_y(i_cent_y),
        .i_cent_z(i_cent_z), .i_frame_dt_ms(i_frame_dt_ms),
        .o_valid(o_valid), .o_track_id(o_track_id), .o_is_new(o_is_new),
        .o_is_dynamic(o_is_dynamic), .o_no_room(o_no_room)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the track store and the registers
    logic [DIST_W-1:0]  dist_cfg  = MAX_DIST_RST;
    logic [LIMIT_W-1:0] miss_cfg  = MISS_LIM_RST;
    logic [SPEED_W-1:0] speed_cfg = MIN_SPEED_RST;
    bit                 trk_live [NSLOT];
    longint unsigned    trk_id   [NSLOT];
    int                 trk_x [NSLOT], trk_y [NSLOT], trk_z [NSLOT];
    int unsigned        trk_miss [NSLOT];
    bit                 trk_used [NSLOT], trk_born [NSLOT];

    t_beat  pending_beats [$];
    t_assoc assoc_expect [$];
    int     err_cnt = 0;
    int     quiet = 0;
    int     gap = 0;
    bit     burst = 1'b0;   // no idling while set

    function automatic longint unsigned sq_dist(int s, int x, int y, int z);
        longint unsigned dx, dy, dz;
        dx = (x > trk_x[s]) ? x - trk_x[s] : trk_x[s] - x;
        dy = (y > trk_y[s]) ? y - trk_y[s] : trk_y[s] - y;
        dz = (z > trk_z[s]) ? z - trk_z[s] : trk_z[s] - z;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // speed >= min_speed, done as d2 * 10^6 >= (min_speed * dt)^2
    function automatic bit moving(longint unsigned d2, logic [DT_W-1:0] dt);
        longint unsigned lim;
        if (dt == '0) return speed_cfg == '0;
        lim = 64'(speed_cfg) * 64'(dt);
        return d2 * 64'd1000000 >= lim * lim;
    endfunction

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_MAX_DIST:  dist_cfg  = data[DIST_W-1:0];
            CFG_MISS_LIM:  miss_cfg  = data[LIMIT_W-1:0];
            CFG_MIN_SPEED: speed_cfg = data[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_association(t_beat b);
        int best, free_s, x, y, z;
        longint unsigned best_d2, lim2, d2, maxid;
        bit any;
        t_assoc r;
        best = -1; free_s = -1; best_d2 = 0; maxid = 0; any = 0;
        if (b.eof) begin
            // age old unmatched tracks, then clear frame marks
            for (int s = 0; s < NSLOT; s++) begin
                if (trk_live[s] && !trk_used[s] && !trk_born[s]) begin
                    if (trk_miss[s] < 255) trk_miss[s]++;
                    if (trk_miss[s] > miss_cfg) trk_live[s] = 0;
                end
                trk_used[s] = 0;
                trk_born[s] = 0;
            end
            return;
        end
        x = int'(b.x); y = int'(b.y); z = int'(b.z);
        lim2 = 64'(dist_cfg) * 64'(dist_cfg);
        for (int s = 0; s < NSLOT; s++) begin
            if (!trk_live[s]) begin
                if (free_s < 0) free_s = s;
                continue;
            end
            if (!any || trk_id[s] > maxid) maxid = trk_id[s];
            any = 1;
            if (trk_used[s] || trk_born[s]) continue;
            d2 = sq_dist(s, x, y, z);
            if (d2 >= lim2) continue;
            // nearest wins, lower id on a tie
            if (best < 0 || d2 < best_d2 || (d2 == best_d2 && trk_id[s] < trk_id[best])) begin
                best = s;
                best_d2 = d2;
            end
        end
        r = '{tid: '0, is_new: 1'b0, dyn: 1'b0, no_room: 1'b0};
        if (best >= 0) begin
            trk_used[best] = 1;
            trk_miss[best] = 0;
            trk_x[best] = x; trk_y[best] = y; trk_z[best] = z;
            r.tid = trk_id[best][TID_W-1:0];
            r.dyn = moving(best_d2, b.dt);
        end else if (free_s < 0 || (any && maxid >= ID_TOP)) begin
            r.no_room = 1'b1;
        end else begin
            trk_live[free_s] = 1;
            trk_id[free_s] = any ? maxid + 1 : 0;
            trk_x[free_s] = x; trk_y[free_s] = y; trk_z[free_s] = z;
            trk_miss[free_s] = 0;
            trk_used[free_s] = 0;
            trk_born[free_s] = 1;
            r.tid = trk_id[free_s][TID_W-1:0];
            r.is_new = 1'b1;
            r.dyn = moving(0, b.dt);
        end
        assoc_expect.insert(assoc_expect.size(), r);
    endtask

    // Sender: mostly short gaps, a few long ones, none during a burst
    function automatic int pick_gap();
        int p;
        if (burst) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin : drive
        logic n_start, n_we;
        t_beat b;
        n_start = start;
        n_we = 1'b0;
        if (i_rst_n) begin
            if (!busy && !start && assoc_expect.size() == 0) quiet++;
            else quiet = 0;
            if (start && !busy) begin
                n_start = 1'b0;
                b.kind = B_ITEM;
                b.eof = i_req_type;
                b.x = i_cent_x; b.y = i_cent_y; b.z = i_cent_z;
                b.dt = i_frame_dt_ms;
                predict_association(b);
                gap = pick_gap();
            end
            if (!n_start && !i_cfg_we && pending_beats.size() > 0) begin
                b = pending_beats[0];
                if (b.kind == B_ITEM) begin
                    if (gap > 0) gap--;
                    else begin
                        void'(pending_beats.pop_front());
                        n_start = 1'b1;
                        i_req_type <= b.eof;
                        i_cent_x <= b.x; i_cent_y <= b.y; i_cent_z <= b.z;
                        i_frame_dt_ms <= b.dt;
                    end
                end else if (b.kind == B_SYNC) begin
                    // sender holds off until every result is in
                    if (quiet > 0) void'(pending_beats.pop_front());
                end else if (quiet >= SETTLE) begin
                    void'(pending_beats.pop_front());
                    n_we = 1'b1;
                    i_cfg_idx <= b.idx;
                    i_cfg_data <= b.data;
                    apply_reg(b.idx, b.data);
                end
            end
        end
        start <= n_start;
        i_cfg_we <= n_we;
    end

    always @(posedge i_clk) begin : check
        t_assoc e;
        if (i_rst_n && o_valid) begin
            if (assoc_expect.size() == 0) begin
                $error("result beat with nothing expected: id %0d", o_track_id);
                err_cnt++;
            end else begin
                e = assoc_expect.pop_front();
                if (o_track_id !== e.tid) begin
                    $error("track_id: expected %0d, got %0d", e.tid, o_track_id);
                    err_cnt++;
                end
                if (o_is_new !== e.is_new) begin
                    $error("is_new: expected %0b, got %0b", e.is_new, o_is_new);
                    err_cnt++;
                end
                if (o_is_dynamic !== e.dyn) begin
                    $error("is_dynamic: expected %0b, got %0b", e.dyn, o_is_dynamic);
                    err_cnt++;
                end
                if (o_no_room !== e.no_room) begin
                    $error("no_room: expected %0b, got %0b", e.no_room, o_no_room);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void add_cent(int x, int y, int z, int dt);
        t_beat b;
        b.kind = B_ITEM; b.eof = 1'b0;
        b.x = CENT_W'(x); b.y = CENT_W'(y); b.z = CENT_W'(z);
        b.dt = DT_W'(dt); b.idx = '0; b.data = '0;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_eof();
        t_beat b;
        b.kind = B_ITEM; b.eof = 1'b1;
        // payload is don't-care on a frame end; keep it random
        b.x = CENT_W'($urandom); b.y = CENT_W'($urandom); b.z = CENT_W'($urandom);
        b.dt = DT_W'($urandom); b.idx = '0; b.data = '0;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        t_beat b;
        b.kind = B_CFG; b.eof = 1'b0;
        b.x = '0; b.y = '0; b.z = '0; b.dt = '0;
        b.idx = idx; b.data = CFG_W'(v);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_sync();
        t_beat b;
        b.kind = B_SYNC; b.eof = 1'b0;
        b.x = '0; b.y = '0; b.z = '0; b.dt = '0; b.idx = '0; b.data = '0;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic int clamp_pos(int v);
        if (v > 250000) return 250000;
        if (v < -250000) return -250000;
        return v;
    endfunction

    // Random frames: a handful of moving objects seen most frames, some clutter
    function automatic void gen_frames(int n_items, int step);
        int ox [8], oy [8], oz [8];
        int cnt, dt, p, nobj;
        cnt = 0;
        nobj = $urandom_range(2, 8);
        for (int i = 0; i < 8; i++) begin
            ox[i] = $urandom_range(0, 400000) - 200000;
            oy[i] = $urandom_range(0, 400000) - 200000;
            oz[i] = $urandom_range(0, 4000) - 2000;
        end
        while (cnt < n_items) begin
            p = $urandom_range(0, 9);
            dt = (p == 0) ? 0 : (p == 1) ? $urandom_range(0, 65535) : $urandom_range(20, 200);
            for (int i = 0; i < nobj; i++) begin
                if ($urandom_range(0, 3) == 0) continue;   // object missed this frame
                ox[i] = clamp_pos(ox[i] + $urandom_range(0, 2 * step) - step);
                oy[i] = clamp_pos(oy[i] + $urandom_range(0, 2 * step) - step);
                oz[i] = clamp_pos(oz[i] + $urandom_range(0, step) - step / 2);
                add_cent(ox[i], oy[i], oz[i], dt);
                cnt++;
            end
            if ($urandom_range(0, 3) == 0) begin
                add_cent($urandom, $urandom, $urandom, dt);   // full-range clutter
                cnt++;
            end
            add_eof();
            cnt++;
            if ($urandom_range(0, 19) == 0) add_sync();
        end
    endfunction

    initial begin : stimulus
        int dists [6];
        int misses [6];
        int speeds [6];
        dists  = '{1000, 0, 1048575, 1500, 600, 3000};
        misses = '{5, 0, 255, 2, 255, 1};
        speeds = '{300, 0, 65535, 0, 1000, 150};

        // Directed: tie, strict distance limit, zero and extreme interval, extremes
        add_cent(-100, 0, 0, 100);            // opens id 0
        add_cent(100, 0, 0, 100);             // opens id 1
        add_cent(-100, 0, 0, 100);            // born tracks excluded: opens id 2
        add_eof();
        add_cent(0, 0, 0, 0);                 // equidistant to ids 0, 1 and 2: lower id
        add_cent(100, 500, 0, 1);             // id 1, fast
        add_cent(-100, 999, 0, 65535);        // id 2, slow
        add_eof();
        add_cent(1000, 0, 0, 50);             // exactly at the limit: no match
        add_cent(262143, 262143, 262143, 65535);
        add_cent(-262144, -262144, -262144, 0);
        add_eof();
        add_eof();
        add_eof();
        add_reg(CFG_MIN_SPEED, 0);            // new tracks now dynamic
        add_reg(CFG_SPARE, 32'hFFFFF);        // index with no register: ignored
        add_cent(-262144, 262143, 0, 0);
        add_cent(5, 5, 5, 7);
        add_eof();
        add_reg(CFG_MIN_SPEED, 65535);
        add_cent(-262144, 262143, 0, 1);      // match but slow
        add_eof();

        for (int ph = 0; ph < 6; ph++) begin
            add_reg(CFG_MAX_DIST, dists[ph]);
            add_reg(CFG_MISS_LIM, misses[ph]);
            add_reg(CFG_MIN_SPEED, speeds[ph]);
            gen_frames(155, (ph == 2) ? 200000 : $urandom_range(50, 2500));
        end
        add_sync();
    end

    initial begin : run_ctl
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // sender runs flat out in bursts and idles between them
        while (pending_beats.size() > 0 || start || busy || assoc_expect.size() > 0
               || quiet < SETTLE) begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) burst <= !burst;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
